// ===== src/music_sequencer_arpeggiator_top_assert.svh =====
// Assertion macros used by the sequencer RTL.
`ifndef MUSIC_SEQUENCER_ARPEGGIATOR_TOP_ASSERT_SVH
`define MUSIC_SEQUENCER_ARPEGGIATOR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define MSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define MSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MSA_ASSERT_IMP(lbl, ante, cons, msg)
`define MSA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/msa_pkg.sv =====
// Shared types and constants of the sequencer.
package msa_pkg;
  typedef enum logic [1:0] {K_WRITE, K_TICK, K_DROP} kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [1:0]  track;
    logic [9:0]  address;
    logic [31:0] word;
  } req_t;

  typedef struct packed {
    logic [1:0]  channel;
    logic [31:0] period;
    logic [31:0] duty;
    logic        last;
  } result_t;

  localparam logic [7:0] OP_SLEEP      = 8'd0;
  localparam logic [7:0] OP_PITCH_LO   = 8'd1;
  localparam logic [7:0] OP_PITCH_HI   = 8'd4;
  localparam logic [7:0] OP_TONE       = 8'd5;
  localparam logic [7:0] OP_INSTR      = 8'd6;
  localparam logic [7:0] OP_TEMPO      = 8'd7;
  localparam logic [7:0] OP_REPEAT     = 8'd8;
  localparam logic [7:0] OP_TONE_SLEEP = 8'd9;
  localparam logic [7:0] OP_TPITCH_LO  = 8'd11;
  localparam logic [7:0] OP_TPITCH_HI  = 8'd14;
  localparam logic [7:0] TPITCH_BIAS   = 8'd10;

  localparam logic [2:0] REG_ACTIVE = 3'd0;
  localparam logic [2:0] REG_TEMPO  = 3'd1;
  localparam logic [2:0] REG_GAIN   = 3'd2;
  localparam logic [2:0] REG_THRESH = 3'd3;
  localparam logic [2:0] REG_LEN0   = 3'd4;
  localparam logic [2:0] REG_LEN1   = 3'd5;
  localparam logic [2:0] REG_LEN2   = 3'd6;
  localparam logic [2:0] REG_LEN3   = 3'd7;

  localparam int          NUM_LEN_REGS = 4;
  localparam int          MAX_PITCHES  = 4;
  localparam logic [31:0] PITCH_RESET  = 32'd255;
endpackage

// ===== src/msa_front.sv =====
// Input queue: accept and classify items for the engine.
module msa_front #(
  parameter int TRACKS    = 4,
  parameter int SEQ_DEPTH = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  logic            in_func,
  input  logic [1:0]      in_track,
  input  logic [9:0]      in_address,
  input  logic [31:0]     in_word,
  input  logic            hold,
  output logic            req_valid,
  output msa_pkg::req_t   req,
  input  logic            req_pop
);
  import msa_pkg::*;

  req_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  req_t       item_w;
  logic       push_w;

  always_comb begin
    item_w.track   = in_track;
    item_w.address = in_address;
    item_w.word    = in_word;
    if (in_func) begin
      item_w.kind = K_TICK;
    end else if (32'(in_track) < TRACKS && 32'(in_address) < SEQ_DEPTH) begin
      item_w.kind = K_WRITE;
    end else begin
      item_w.kind = K_DROP;
    end
  end

  assign in_full   = (cnt_r == 2'd2) || hold;
  assign push_w    = in_push && !in_full;
  assign req_valid = (cnt_r != 2'd0);
  assign req       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_w) begin
        q_r[wp_r] <= item_w;
        wp_r      <= ~wp_r;
      end
      if (req_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push_w) - 2'(req_pop);
    end
  end
endmodule

// ===== src/msa_outq.sv =====
// Result queue between the engine and the output ports.
module msa_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  msa_pkg::result_t  din,
  output logic              full,
  input  logic              pop,
  output msa_pkg::result_t  dout,
  output logic              empty
);
  import msa_pkg::*;

  result_t    q_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       wr_w, rd_w;

  assign full  = (cnt_r == 3'd4);
  assign empty = (cnt_r == 3'd0);
  assign dout  = q_r[rp_r];
  assign wr_w  = push && !full;
  assign rd_w  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      if (wr_w) begin
        q_r[wp_r] <= din;
        wp_r      <= wp_r + 2'd1;
      end
      if (rd_w) begin
        rp_r <= rp_r + 2'd1;
      end
      cnt_r <= cnt_r + 3'(wr_w) - 3'(rd_w);
    end
  end
endmodule

// ===== src/msa_core.sv =====
// Playback engine: sequence store, per-track command execution and channel output.
`include "music_sequencer_arpeggiator_top_assert.svh"
module msa_core #(
  parameter int TRACKS    = 4,
  parameter int SEQ_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              req_valid,
  input  msa_pkg::req_t     req,
  output logic              req_pop,
  output logic              clearing,
  output logic              res_push,
  output msa_pkg::result_t  res,
  input  logic              res_full
);
  import msa_pkg::*;

  localparam int TW    = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int PW    = $clog2(SEQ_DEPTH);
  localparam int AW    = TW + PW;
  localparam int NW    = $clog2(TRACKS + 1);
  localparam int MDEP  = TRACKS * SEQ_DEPTH;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_SYNC, S_TRK, S_CODE, S_ARG, S_OUT, S_EMIT
  } state_t;

  state_t        state_r;
  logic [AW-1:0] clr_r;
  logic [NW-1:0] t_r;
  logic [2:0]    k_r;
  logic [7:0]    code_r;

  logic [31:0]   mem [0:MDEP-1];
  logic [31:0]   rdata_r;
  logic [AW-1:0] ra_w, wa_w;
  logic [31:0]   wd_w;
  logic          we_w;

  logic [PW-1:0] pos_r   [TRACKS];
  logic [PW-1:0] jump_r  [TRACKS];
  logic [47:0]   sleep_r [TRACKS];
  logic [31:0]   pl_r    [TRACKS][MAX_PITCHES];
  logic [2:0]    pcnt_r  [TRACKS];
  logic [1:0]    pidx_r  [TRACKS];
  logic [7:0]    poly_r  [TRACKS];
  logic [31:0]   tone_r  [TRACKS];
  logic          inst_r  [TRACKS];
  logic [15:0]   tempo_r;

  logic [2:0]    act_r;
  logic [15:0]   gain_r;
  logic [7:0]    thr_r;
  logic [10:0]   len_r [NUM_LEN_REGS];

  logic [31:0]   period_r;
  logic [47:0]   prod_r;
  logic          last_r;

  logic [NW-1:0] n_w;
  logic [TW-1:0] tix;
  logic [TRACKS-1:0] end_w, play_w;
  logic          sync_w, later_w;
  logic [7:0]    c_w;
  logic          known_w, is_p_w, is_tp_w;
  logic [2:0]    np_w, lastk_w;
  logic [PW-1:0] off_w;
  logic [47:0]   slp_w;
  logic [1:0]    eff_w;
  logic [7:0]    pc_w;

  assign tix      = t_r[TW-1:0];
  assign n_w      = (32'(act_r) > TRACKS) ? NW'(TRACKS) : NW'(act_r);
  assign clearing = (state_r == S_CLR);
  assign req_pop  = (state_r == S_IDLE) && req_valid;
  assign c_w      = rdata_r[7:0];
  assign known_w  = (c_w <= OP_TONE_SLEEP) || (c_w >= OP_TPITCH_LO && c_w <= OP_TPITCH_HI);
  assign is_tp_w  = (code_r >= OP_TPITCH_LO) && (code_r <= OP_TPITCH_HI);
  assign is_p_w   = is_tp_w || ((code_r >= OP_PITCH_LO) && (code_r <= OP_PITCH_HI));
  assign np_w     = is_tp_w ? 3'(code_r - TPITCH_BIAS) : 3'(code_r);
  assign slp_w    = 48'(rdata_r) * 48'(tempo_r);
  assign eff_w    = pidx_r[tix];
  assign pc_w     = poly_r[tix] + 8'd1;

  always_comb begin
    if (is_p_w) begin
      lastk_w = np_w + 3'd1 + 3'(is_tp_w);
    end else if (code_r == OP_TONE_SLEEP) begin
      lastk_w = 3'd2;
    end else begin
      lastk_w = 3'd1;
    end
  end

  always_comb begin
    sync_w  = 1'b0;
    later_w = 1'b0;
    for (int i = 0; i < TRACKS; i++) begin
      end_w[i]  = (17'(pos_r[i]) + 17'd1) >=
                  ((i < NUM_LEN_REGS) ? 17'(len_r[i % NUM_LEN_REGS]) : 17'd1);
      play_w[i] = (NW'(i) < n_w) && inst_r[i] && (pcnt_r[i] != 3'd0);
      if (NW'(i) < n_w && end_w[i] && sleep_r[i] == 48'd0) begin
        sync_w = 1'b1;
      end
      if (NW'(i) > t_r && play_w[i]) begin
        later_w = 1'b1;
      end
    end
  end

  // Read address: code word in S_TRK, first argument in S_CODE, next argument in S_ARG.
  always_comb begin
    unique case (state_r)
      S_TRK:   off_w = '0;
      S_CODE:  off_w = PW'(1);
      default: off_w = PW'(k_r) + PW'(1);
    endcase
    ra_w = {tix, pos_r[tix] + off_w};
    we_w = 1'b0;
    wa_w = clr_r;
    wd_w = '0;
    if (state_r == S_CLR) begin
      we_w = 1'b1;
    end else if (req_pop && req.kind == K_WRITE) begin
      we_w = 1'b1;
      wa_w = {TW'(req.track), PW'(req.address)};
      wd_w = req.word;
    end
  end

  always_ff @(posedge clk) begin
    if (we_w) begin
      mem[wa_w] <= wd_w;
    end
    rdata_r <= mem[ra_w];
  end

  assign res_push    = (state_r == S_EMIT) && !res_full;
  assign res.channel = 2'(t_r);
  assign res.period  = period_r;
  assign res.duty    = (prod_r[47:32] != 16'd0) ? 32'hFFFF_FFFF : prod_r[31:0];
  assign res.last    = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      t_r     <= '0;
      k_r     <= '0;
      code_r  <= '0;
      tempo_r <= 16'd1;
      act_r   <= 3'd4;
      gain_r  <= 16'd512;
      thr_r   <= 8'd2;
      for (int i = 0; i < NUM_LEN_REGS; i++) begin
        len_r[i] <= 11'd1;
      end
      for (int i = 0; i < TRACKS; i++) begin
        pos_r[i]   <= '0;
        jump_r[i]  <= '0;
        sleep_r[i] <= '0;
        pcnt_r[i]  <= '0;
        pidx_r[i]  <= '0;
        poly_r[i]  <= '0;
        tone_r[i]  <= '0;
        inst_r[i]  <= 1'b0;
        for (int j = 0; j < MAX_PITCHES; j++) begin
          pl_r[i][j] <= PITCH_RESET;
        end
      end
    end else begin
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(MDEP - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid && req.kind == K_TICK) begin
            state_r <= S_SYNC;
          end
        end
        S_SYNC: begin
          if (sync_w) begin
            for (int i = 0; i < TRACKS; i++) begin
              if (NW'(i) < n_w) begin
                pos_r[i]   <= '0;
                jump_r[i]  <= '0;
                sleep_r[i] <= '0;
              end
            end
          end
          t_r     <= '0;
          state_r <= S_TRK;
        end
        S_TRK: begin
          priority if (t_r == n_w) begin
            t_r     <= '0;
            state_r <= S_OUT;
          end else if (sleep_r[tix] != 48'd0) begin
            sleep_r[tix] <= sleep_r[tix] - 48'd1;
            t_r          <= t_r + NW'(1);
          end else if (end_w[tix]) begin
            t_r <= t_r + NW'(1);
          end else begin
            state_r <= S_CODE;
          end
        end
        S_CODE: begin
          code_r <= c_w;
          priority if (!known_w) begin
            t_r     <= t_r + NW'(1);
            state_r <= S_TRK;
          end else if (c_w == OP_REPEAT && jump_r[tix] == pos_r[tix]) begin
            pos_r[tix]  <= pos_r[tix] + PW'(2);
            jump_r[tix] <= '0;
            t_r         <= t_r + NW'(1);
            state_r     <= S_TRK;
          end else begin
            k_r     <= 3'd1;
            state_r <= S_ARG;
          end
        end
        S_ARG: begin
          if (is_p_w) begin
            if (k_r <= np_w) begin
              pl_r[tix][2'(k_r - 3'd1)] <= rdata_r;
            end
            if (is_tp_w && k_r == np_w + 3'd1) begin
              tone_r[tix] <= rdata_r;
            end
            if (k_r == lastk_w) begin
              sleep_r[tix] <= slp_w;
              pcnt_r[tix]  <= np_w;
              pidx_r[tix]  <= '0;
            end
          end else begin
            unique case (code_r)
              OP_SLEEP:  sleep_r[tix] <= slp_w;
              OP_TONE:   tone_r[tix]  <= rdata_r;
              OP_INSTR:  inst_r[tix]  <= (rdata_r == 32'd1);
              OP_TEMPO:  tempo_r      <= rdata_r[15:0];
              OP_REPEAT: jump_r[tix]  <= pos_r[tix];
              OP_TONE_SLEEP: begin
                if (k_r == 3'd1) begin
                  tone_r[tix] <= rdata_r;
                end else begin
                  sleep_r[tix] <= slp_w;
                end
              end
              default: ;
            endcase
          end
          if (k_r == lastk_w) begin
            if (code_r == OP_REPEAT) begin
              pos_r[tix] <= pos_r[tix] - rdata_r[PW-1:0];
            end else begin
              pos_r[tix] <= pos_r[tix] + PW'(lastk_w) + PW'(1);
            end
            t_r     <= t_r + NW'(1);
            state_r <= S_TRK;
          end else begin
            k_r <= k_r + 3'd1;
          end
        end
        S_OUT: begin
          priority if (t_r == n_w) begin
            state_r <= S_IDLE;
          end else if (play_w[tix]) begin
            if (3'(pidx_r[tix]) >= pcnt_r[tix]) begin
              pidx_r[tix] <= '0;
              period_r    <= pl_r[tix][0];
            end else begin
              period_r <= pl_r[tix][pidx_r[tix]];
            end
            prod_r  <= 48'(tone_r[tix]) * 48'(gain_r);
            last_r  <= !later_w;
            state_r <= S_EMIT;
          end else begin
            t_r <= t_r + NW'(1);
          end
        end
        S_EMIT: begin
          if (!res_full) begin
            if (pc_w >= thr_r) begin
              poly_r[tix] <= '0;
              pidx_r[tix] <= (3'(eff_w) == pcnt_r[tix] - 3'd1) ? 2'd0 : eff_w + 2'd1;
            end else begin
              poly_r[tix] <= pc_w;
            end
            t_r     <= t_r + NW'(1);
            state_r <= S_OUT;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ACTIVE: act_r <= cfg_data[2:0];
          REG_TEMPO:  tempo_r <= cfg_data;
          REG_GAIN:   gain_r <= cfg_data;
          REG_THRESH: thr_r  <= cfg_data[7:0];
          REG_LEN0:   len_r[0] <= cfg_data[10:0];
          REG_LEN1:   len_r[1] <= cfg_data[10:0];
          REG_LEN2:   len_r[2] <= cfg_data[10:0];
          REG_LEN3:   len_r[3] <= cfg_data[10:0];
          default: ;
        endcase
      end
    end
  end

  `MSA_ASSERT_IMP(a_clr_nopop, state_r == S_CLR, !req_pop, "item taken during clear")
  `MSA_ASSERT_NXT(a_emit_adv, state_r == S_EMIT && !res_full, state_r == S_OUT, "emit stuck")
  `MSA_ASSERT_IMP(a_arg_bound, state_r == S_ARG, k_r != 3'd0 && k_r <= lastk_w, "bad arg step")
  `MSA_ASSERT_IMP(a_push_room, res_push, !res_full && last_r == !later_w, "bad result push")
endmodule

// ===== src/music_sequencer_arpeggiator_top.sv =====
// Multi-track sequencer with arpeggiator: top level.
// Write item: queued in the input queue, stored in the cycle the engine takes it; no results.
// Tick: per active track a sleep decrement, nothing once ended, or one command with its arguments
// (an unknown code or a taken repeat just moves on to the next track), then one result per sounding channel;
// one tick at a time, stalled while the result queue is full.
// Reset: a clear pass over all TRACKS*SEQ_DEPTH words zeroes the store; in_full stays high meanwhile.
module music_sequencer_arpeggiator_top #(
  parameter int TRACKS    = 4,
  parameter int SEQ_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_func,
  input  logic [1:0]  in_track,
  input  logic [9:0]  in_address,
  input  logic [31:0] in_word,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_channel,
  output logic [31:0] out_period,
  output logic [31:0] out_duty,
  output logic        out_last
);
  import msa_pkg::*;

  req_t    req;
  logic    req_valid, req_pop, clearing;
  result_t res, head;
  logic    res_push, res_full;

  // Front: hold up to two items, classify writes, ticks and out-of-range writes.
  msa_front #(.TRACKS(TRACKS), .SEQ_DEPTH(SEQ_DEPTH)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_func, .in_track, .in_address, .in_word,
    .hold(clearing), .req_valid, .req, .req_pop
  );

  // Back: store writes, run track commands, produce per-channel settings.
  msa_core #(.TRACKS(TRACKS), .SEQ_DEPTH(SEQ_DEPTH)) u_core (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .req_valid, .req, .req_pop,
    .clearing, .res_push, .res, .res_full
  );

  // Results wait here until the consumer pops each transfer.
  msa_outq u_outq (
    .clk, .rst_n, .push(res_push), .din(res), .full(res_full),
    .pop(out_pop), .dout(head), .empty(out_empty)
  );

  assign out_channel = head.channel;
  assign out_period  = head.period;
  assign out_duty    = head.duty;
  assign out_last    = head.last;
endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the multi-track sequencer with arpeggiator.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import msa_pkg::*;

  localparam bit FUNC_WRITE = 1'b0;
  localparam bit FUNC_TICK  = 1'b1;
  localparam logic [7:0] OP_BOGUS = 8'h3F;

  typedef struct {
    bit        func;
    bit [1:0]  trk;
    bit [9:0]  adr;
    bit [31:0] w;
  } seq_item_t;

  // Scoreboard: tracks sequencer state and holds the channel settings each tick should emit.
  class seq_scoreboard;
    bit [31:0] store[4][1024];
    bit [9:0]  pos[4];
    bit [9:0]  mark[4];
    bit [47:0] sleep_left[4];
    bit [15:0] tempo;
    bit [31:0] pitches[4][4];
    bit [2:0]  pcount[4];
    bit [1:0]  pidx[4];
    bit [7:0]  pcnt[4];
    bit [31:0] tone_v[4];
    bit        voiced[4];
    bit [2:0]  active;
    bit [15:0] start_tempo;
    bit [15:0] gain;
    bit [7:0]  thresh;
    bit [10:0] len[4];
    result_t   settings_q[$];
    int        errors;
    int        checked;
    int        ticks;

    function new();
      for (int t = 0; t < 4; t++) begin
        for (int a = 0; a < 1024; a++) store[t][a] = '0;
        for (int i = 0; i < 4; i++) pitches[t][i] = PITCH_RESET;
        pos[t] = '0; mark[t] = '0; sleep_left[t] = '0;
        pcount[t] = '0; pidx[t] = '0; pcnt[t] = '0; tone_v[t] = '0; voiced[t] = 1'b0;
        len[t] = 11'd1;
      end
      active = 3'd4; start_tempo = 16'd1; tempo = 16'd1; gain = 16'd512; thresh = 8'd2;
      errors = 0; checked = 0; ticks = 0;
    endfunction

    function void report(string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void set_reg(bit [2:0] idx, bit [15:0] v);
      case (idx)
        REG_ACTIVE: active = v[2:0];
        REG_TEMPO: begin
          start_tempo = v;
          tempo = v;
        end
        REG_GAIN:   gain = v;
        REG_THRESH: thresh = v[7:0];
        REG_LEN0:   len[0] = v[10:0];
        REG_LEN1:   len[1] = v[10:0];
        REG_LEN2:   len[2] = v[10:0];
        REG_LEN3:   len[3] = v[10:0];
        default: ;
      endcase
    endfunction

    function bit ended(int t);
      return (int'(pos[t]) + 1) >= int'(len[t]);
    endfunction

    function bit [31:0] arg(int t, int off);
      return store[t][10'(pos[t] + 10'(off))];
    endfunction

    function bit [47:0] sleep_for(bit [31:0] w);
      return 48'(w) * 48'(tempo);
    endfunction

    function void load_pitches(int t, int n);
      for (int i = 0; i < n; i++) pitches[t][i] = arg(t, i + 1);
      pcount[t] = 3'(n);
      pidx[t] = '0;
    endfunction

    // One sleep decrement or one command for track t; nothing once the track has ended.
    function void step_track(int t);
      bit [7:0] code;
      int       n;
      if (sleep_left[t] != 0) begin
        sleep_left[t]--;
        return;
      end
      if (ended(t)) return;
      code = 8'(arg(t, 0));
      if (code == OP_SLEEP) begin
        sleep_left[t] = sleep_for(arg(t, 1));
        pos[t] += 10'd2;
      end else if (code >= OP_PITCH_LO && code <= OP_PITCH_HI) begin
        n = int'(code);
        sleep_left[t] = sleep_for(arg(t, n + 1));
        load_pitches(t, n);
        pos[t] += 10'(n + 2);
      end else if (code >= OP_TPITCH_LO && code <= OP_TPITCH_HI) begin
        n = int'(code - TPITCH_BIAS);
        tone_v[t] = arg(t, n + 1);
        sleep_left[t] = sleep_for(arg(t, n + 2));
        load_pitches(t, n);
        pos[t] += 10'(n + 3);
      end else if (code == OP_TONE) begin
        tone_v[t] = arg(t, 1);
        pos[t] += 10'd2;
      end else if (code == OP_INSTR) begin
        voiced[t] = (arg(t, 1) == 32'd1);
        pos[t] += 10'd2;
      end else if (code == OP_TEMPO) begin
        tempo = 16'(arg(t, 1));
        pos[t] += 10'd2;
      end else if (code == OP_REPEAT) begin
        if (mark[t] == pos[t]) begin
          mark[t] = '0;
          pos[t] += 10'd2;
        end else begin
          mark[t] = pos[t];
          pos[t] -= 10'(arg(t, 1));
        end
      end else if (code == OP_TONE_SLEEP) begin
        tone_v[t] = arg(t, 1);
        sleep_left[t] = sleep_for(arg(t, 2));
        pos[t] += 10'd3;
      end
      // any other code: hold position
    endfunction

    function void note_input(seq_item_t it);
      int        n;
      bit [63:0] prod;
      result_t   r;
      if (it.func == FUNC_WRITE) begin
        store[it.trk][it.adr] = it.w;
        return;
      end
      ticks++;
      n = (active > 3'd4) ? 4 : int'(active);
      for (int t = 0; t < n; t++) begin
        if (ended(t) && sleep_left[t] == 0) begin
          for (int i = 0; i < n; i++) begin
            pos[i] = '0; mark[i] = '0; sleep_left[i] = '0;
          end
          break;
        end
      end
      for (int t = 0; t < n; t++) step_track(t);
      for (int t = 0; t < n; t++) begin
        if (!voiced[t] || pcount[t] == 0) continue;
        if (pidx[t] >= pcount[t]) pidx[t] = '0;
        prod = 64'(tone_v[t]) * 64'(gain);
        r.channel = 2'(t);
        r.period  = pitches[t][pidx[t]];
        r.duty    = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
        r.last    = 1'b0;
        settings_q.push_back(r);
        pcnt[t]++;
        if (pcnt[t] >= thresh) begin
          pcnt[t] = '0;
          pidx[t] = (3'(pidx[t]) == pcount[t] - 3'd1) ? 2'd0 : pidx[t] + 2'd1;
        end
      end
      // flag the final setting of this tick
      if (settings_q.size() > 0 && n > 0) begin
        for (int t = n - 1; t >= 0; t--) begin
          if (voiced[t] && pcount[t] != 0) begin
            settings_q[settings_q.size() - 1].last = 1'b1;
            break;
          end
        end
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (settings_q.size() == 0) begin
        report($sformatf("unexpected result ch=%0d period=%h", got.channel, got.period));
        return;
      end
      want = settings_q.pop_front();
      checked++;
      if (got.channel !== want.channel)
        report($sformatf("channel %0d, want %0d", got.channel, want.channel));
      if (got.period !== want.period)
        report($sformatf("ch%0d period %h, want %h", want.channel, got.period, want.period));
      if (got.duty !== want.duty)
        report($sformatf("ch%0d duty %h, want %h", want.channel, got.duty, want.duty));
      if (got.last !== want.last)
        report($sformatf("ch%0d last %0d, want %0d", want.channel, got.last, want.last));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_push;
  logic        in_full;
  logic        in_func;
  logic [1:0]  in_track;
  logic [9:0]  in_address;
  logic [31:0] in_word;
  logic        out_empty;
  logic        out_pop;
  logic [1:0]  out_channel;
  logic [31:0] out_period;
  logic [31:0] out_duty;
  logic        out_last;

  seq_scoreboard sb = new();
  seq_item_t     stim_q[$];
  int            items_sent;
  int            phases_run;
  bit            long_hold_done;

  music_sequencer_arpeggiator_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_push(in_push), .in_full(in_full), .in_func(in_func), .in_track(in_track),
    .in_address(in_address), .in_word(in_word),
    .out_empty(out_empty), .out_pop(out_pop), .out_channel(out_channel),
    .out_period(out_period), .out_duty(out_duty), .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Input side: drain the stimulus queue in bursts with random gaps between them.
  initial begin
    seq_item_t cur;
    bit        xfer;
    bit        nxt_push;
    int        burst_left;
    int        gap_left;
    in_push = 1'b0; in_func = 1'b0; in_track = '0; in_address = '0; in_word = '0;
    burst_left = 0; gap_left = 0; items_sent = 0;
    forever begin
      @(posedge clk);
      xfer = in_push && !in_full;
      if (xfer) begin
        sb.note_input(cur);
        items_sent++;
      end
      if (!in_push || xfer) begin
        nxt_push = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (rst_n && stim_q.size() > 0) begin
          cur = stim_q.pop_front();
          in_func <= cur.func;
          in_track <= cur.trk;
          in_address <= cur.adr;
          in_word <= cur.w;
          nxt_push = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 20);
            // some bursts run back to back with no gap at all
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
        in_push <= nxt_push;
      end
    end
  end

  // Result side: pop on a pattern that rotates through three modes; hold off
  // once for a long stretch so the block backs up and stalls its input.
  initial begin
    result_t got;
    int      rx_cyc;
    int      hold_left;
    int      pops;
    bit      nxt_pop;
    out_pop = 1'b0; rx_cyc = 0; hold_left = 0; pops = 0; long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      rx_cyc++;
      if (out_pop && !out_empty) begin
        got.channel = out_channel;
        got.period  = out_period;
        got.duty    = out_duty;
        got.last    = out_last;
        sb.check_result(got);
        pops++;
        if (pops == 40 && !long_hold_done) begin
          hold_left = 900;
          long_hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_pop = 1'b0;
      end else begin
        case ((rx_cyc / 256) % 3)
          0:       nxt_pop = 1'b1;
          1:       nxt_pop = 1'($urandom_range(0, 1));
          default: nxt_pop = (rx_cyc % 5) != 0;
        endcase
      end
      out_pop <= nxt_pop;
    end
  end

  task automatic cfg_write(bit [2:0] idx, bit [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_item(bit func, bit [1:0] trk, bit [9:0] adr, bit [31:0] w);
    seq_item_t it;
    it.func = func; it.trk = trk; it.adr = adr; it.w = w;
    stim_q.push_back(it);
  endtask

  task automatic queue_ticks(int n);
    for (int i = 0; i < n; i++)
      queue_item(FUNC_TICK, 2'($urandom()), 10'($urandom()), $urandom());
  endtask

  // Wait until all stimulus is taken and every expected setting has come out.
  task automatic wait_idle();
    while (stim_q.size() > 0 || in_push) @(posedge clk);
    while (sb.settings_q.size() > 0) @(posedge clk);
    // ticks that emit nothing may still sit in the input queue and the engine
    repeat (200) @(posedge clk);
  endtask

  function automatic bit [31:0] opword(bit [7:0] op);
    return ($urandom() & 32'hFFFF_FF00) | 32'(op);
  endfunction

  function automatic bit [31:0] sleep_word();
    return ($urandom_range(0, 15) == 0) ? $urandom() : 32'($urandom_range(0, 2));
  endfunction

  // Build a program of at least n words with random content; return its length.
  task automatic build_program(bit [1:0] trk, int n, output int words);
    bit [31:0] w[$];
    int        k;
    int        sel;
    w.push_back(opword(OP_INSTR));
    w.push_back(32'd1);
    while (w.size() < n) begin
      sel = $urandom_range(0, 12);
      case (sel)
        0: begin
          w.push_back(opword(OP_SLEEP));
          w.push_back(sleep_word());
        end
        1, 2, 3: begin
          k = $urandom_range(1, 4);
          w.push_back(opword(OP_PITCH_LO + 8'(k - 1)));
          for (int i = 0; i < k; i++) w.push_back($urandom());
          w.push_back(sleep_word());
        end
        4, 5: begin
          k = $urandom_range(1, 4);
          w.push_back(opword(OP_TPITCH_LO + 8'(k - 1)));
          for (int i = 0; i < k; i++) w.push_back($urandom());
          w.push_back($urandom_range(0, 1) ? $urandom() : 32'($urandom_range(0, 300)));
          w.push_back(sleep_word());
        end
        6: begin
          w.push_back(opword(OP_TONE));
          w.push_back($urandom());
        end
        7: begin
          w.push_back(opword(OP_INSTR));
          w.push_back($urandom_range(0, 3) != 0 ? 32'd1 : $urandom());
        end
        8: begin
          w.push_back(opword(OP_TEMPO));
          w.push_back(($urandom() & 32'hFFFF_0000) | 32'($urandom_range(0, 3)));
        end
        9: begin
          w.push_back(opword(OP_REPEAT));
          w.push_back(($urandom() & 32'hFFFF_FC00) | 32'($urandom_range(0, w.size() - 1)));
        end
        10, 11: begin
          w.push_back(opword(OP_TONE_SLEEP));
          w.push_back($urandom());
          w.push_back(sleep_word());
        end
        default: begin
          // unknown code stalls the track; keep it rare
          if ($urandom_range(0, 3) == 0) w.push_back(opword(OP_BOGUS));
        end
      endcase
    end
    foreach (w[i]) queue_item(FUNC_WRITE, trk, 10'(i), w[i]);
    words = w.size();
  endtask

  // Directed program on track 0: each command kind, saturation and the stall.
  task automatic directed_phase();
    bit [31:0] w[$];
    w = '{32'(OP_INSTR), 32'd1,
          32'(OP_PITCH_HI), 32'd0, 32'hFFFF_FFFF, 32'd255, 32'hA5A5_A5A5, 32'd1,
          32'(OP_TONE), 32'hFFFF_FFFF,
          32'(OP_PITCH_LO), 32'd7, 32'd0,
          32'(OP_SLEEP), 32'd2,
          32'(OP_TEMPO), 32'hFFFF_0002,
          32'(OP_REPEAT), 32'd2,
          32'(OP_TONE_SLEEP), 32'h1234, 32'd1,
          32'(OP_TPITCH_LO), 32'd9, 32'd3, 32'd0,
          32'(OP_INSTR), 32'd0,
          32'(OP_INSTR), 32'd1,
          32'(OP_TPITCH_HI), 32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF, 32'd5, 32'd0,
          32'(OP_BOGUS)};
    cfg_write(REG_ACTIVE, 16'd1);
    cfg_write(REG_LEN0, 16'(w.size() + 4));
    foreach (w[i]) queue_item(FUNC_WRITE, 2'd0, 10'(i), w[i]);
    queue_ticks(32);
    wait_idle();
  endtask

  task automatic random_phase(int p);
    int        n;
    int        words;
    bit [15:0] v;
    // active count: mostly in range, once zero and once above the track count
    if (p == 2)      v = 16'd0;
    else if (p == 3) v = 16'hFFFF;
    else             v = 16'($urandom_range(1, 4)) | (16'($urandom()) & 16'hFFF8);
    cfg_write(REG_ACTIVE, v);
    case (p % 4)
      0: v = 16'd0;
      1: v = 16'hFFFF;
      default: v = 16'($urandom_range(1, 2));
    endcase
    cfg_write(REG_TEMPO, v);
    case (p % 3)
      0: v = 16'hFFFF;
      1: v = 16'd0;
      default: v = 16'($urandom());
    endcase
    cfg_write(REG_GAIN, v);
    case (p % 5)
      0: v = 16'd0;
      1: v = 16'd1;
      2: v = 16'd255;
      default: v = 16'($urandom_range(1, 4)) | (16'($urandom()) & 16'hFF00);
    endcase
    cfg_write(REG_THRESH, v);
    n = (p == 3) ? 4 : (p == 2 ? 0 : int'(sb.active));
    for (int t = 0; t < 4; t++) begin
      if (t < n || t == 0) begin
        build_program(2'(t), $urandom_range(6, 16), words);
        // let the store writes land before touching the length register
        wait_idle();
        case ($urandom_range(0, 9))
          0:       v = 16'd0;
          1:       v = 16'd2047;
          2:       v = 16'd1024;
          default: v = 16'(words + $urandom_range(0, 3));
        endcase
        cfg_write(REG_LEN0 + 3'(t), v);
      end
    end
    for (int i = 0; i < 30; i++) begin
      // noise: a stray store write now and then
      if ($urandom_range(0, 9) == 0)
        queue_item(FUNC_WRITE, 2'($urandom()), 10'($urandom_range(0, 20)), $urandom());
      else
        queue_ticks(1);
    end
    wait_idle();
    phases_run++;
  endtask

  initial begin
    rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0; phases_run = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    directed_phase();
    while (items_sent < 330 || phases_run < 5) random_phase(phases_run);
    wait_idle();
    repeat (100) @(posedge clk);
    if (sb.settings_q.size() > 0)
      sb.report($sformatf("%0d expected settings never came out", sb.settings_q.size()));
    $display("Covered %0d items, %0d ticks and %0d channel settings over %0d phases.",
             items_sent, sb.ticks, sb.checked, phases_run + 1);
    $display("Long output hold-off %0s; mismatches: %0d.",
             long_hold_done ? "done" : "not reached", sb.errors);
    if (sb.errors == 0) begin
      $display("PASS music_sequencer_arpeggiator_top");
    end else begin
      $display("FAIL music_sequencer_arpeggiator_top");
    end
    $finish;
  end

  // Watchdog: covers the store clear after reset and the slowest legal run many times over.
  initial begin
    #5ms;
    $display("Timeout with %0d settings outstanding.", sb.settings_q.size());
    $display("FAIL music_sequencer_arpeggiator_top");
    $finish;
  end
endmodule
